// ----- hw/rtl/nois_pkg.sv -----
// Shared constants, codes and types for the note-off id stamper.
package nois_pkg;

    localparam int CHAN_W          = 4;
    localparam int PITCH_W         = 7;
    localparam int VEL_W           = 7;
    localparam int TICK_W          = 32;
    localparam int NOTE_ID_W       = 16;
    localparam int KIND_W          = 2;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ON    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OFF   = 2'd2;

    typedef enum logic [1:0] {
        OP_OTHER,
        OP_ON,
        OP_OFF
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT
    } back_state_t;

endpackage

// ----- hw/rtl/note_off_id_stamper.sv -----
// Top level of the note-off id stamper: configuration register, front end and back end.
//
//  Channel   Handshake              Payload
//  in        in_valid / in_stall    first, event_kind, channel, pitch, velocity, tick, note_id
//  out       out_valid / out_stall  result_id, paired, stamped, overflow
//  config    cfg_wr_en              cfg_wr_data (invalid id)
//
// The front end classifies an event in the cycle it is accepted and queues it two deep.
// Other events, note-ons and offs against an empty stack finish in the idle state; an off
// searches the stack from the top one entry at a time and after a match moves each entry
// above it down one at a time, since the stack memory has one read and one write port.
// Reset empties the stack by clearing its count; the stack memory itself is not cleared.
// Either side may stall on its own; a held result does not stop the queue from filling.
module note_off_id_stamper
    import nois_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [NOTE_ID_W-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 first,
    input  logic [KIND_W-1:0]    event_kind,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [PITCH_W-1:0]   pitch,
    input  logic [VEL_W-1:0]     velocity,
    input  logic [TICK_W-1:0]    tick,
    input  logic [NOTE_ID_W-1:0] note_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NOTE_ID_W-1:0] result_id,
    output logic                 paired,
    output logic                 stamped,
    output logic                 overflow
);

    localparam int KW = (ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W;

    logic [NOTE_ID_W-1:0] inval_reg;
    logic                 q_valid;
    logic                 q_pop;
    op_t                  q_op;
    logic                 q_first;
    logic [CHAN_W-1:0]    q_channel;
    logic [PITCH_W-1:0]   q_pitch;
    logic [TICK_W-1:0]    q_tick;
    logic [KW-1:0]        q_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inval_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            inval_reg <= cfg_wr_data;
        end
    end

    nois_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first      (first),
        .event_kind (event_kind),
        .channel    (channel),
        .pitch      (pitch),
        .velocity   (velocity),
        .tick       (tick),
        .note_id    (note_id),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_op       (q_op),
        .q_first    (q_first),
        .q_channel  (q_channel),
        .q_pitch    (q_pitch),
        .q_tick     (q_tick),
        .q_id       (q_id)
    );

    nois_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_op       (q_op),
        .q_first    (q_first),
        .q_channel  (q_channel),
        .q_pitch    (q_pitch),
        .q_tick     (q_tick),
        .q_id       (q_id),
        .inval_id   (inval_reg[KW-1:0]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_id  (result_id),
        .paired     (paired),
        .stamped    (stamped),
        .overflow   (overflow)
    );

endmodule

// ----- hw/rtl/nois_front.sv -----
// Front end: accepts events, classifies them and queues stack commands.
module nois_front
    import nois_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             first,
    input  logic [KIND_W-1:0]                event_kind,
    input  logic [CHAN_W-1:0]                channel,
    input  logic [PITCH_W-1:0]               pitch,
    input  logic [VEL_W-1:0]                 velocity,
    input  logic [TICK_W-1:0]                tick,
    input  logic [NOTE_ID_W-1:0]             note_id,
    output logic                             q_valid,
    input  logic                             q_pop,
    output op_t                              q_op,
    output logic                             q_first,
    output logic [CHAN_W-1:0]                q_channel,
    output logic [PITCH_W-1:0]               q_pitch,
    output logic [TICK_W-1:0]                q_tick,
    output logic [((ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W)-1:0] q_id
);

    localparam int KW  = (ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W;
    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW  = $clog2(QUEUE_DEPTH + 1);

    op_t               op_in;
    logic              push;
    logic              pop;

    op_t               q_op_reg    [QUEUE_DEPTH];
    logic              q_first_reg [QUEUE_DEPTH];
    logic [CHAN_W-1:0] q_chan_reg  [QUEUE_DEPTH];
    logic [PITCH_W-1:0] q_pitch_reg [QUEUE_DEPTH];
    logic [TICK_W-1:0] q_tick_reg  [QUEUE_DEPTH];
    logic [KW-1:0]     q_id_reg    [QUEUE_DEPTH];

    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [NW-1:0]     fill_reg;
    logic [NW-1:0]     fill_next;

    always_comb
    begin
        unique case (event_kind)
            KIND_ON:
            begin
                op_in = (velocity != '0) ? OP_ON : OP_OFF;
            end
            KIND_OFF:
            begin
                op_in = OP_OFF;
            end
            default:
            begin
                op_in = OP_OTHER;
            end
        endcase
    end

    assign in_stall = (fill_reg == NW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_op_reg[wr_ptr_reg]    <= op_in;
            q_first_reg[wr_ptr_reg] <= first;
            q_chan_reg[wr_ptr_reg]  <= channel;
            q_pitch_reg[wr_ptr_reg] <= pitch;
            q_tick_reg[wr_ptr_reg]  <= tick;
            q_id_reg[wr_ptr_reg]    <= note_id[KW-1:0];
        end
    end

    assign q_op      = q_op_reg[rd_ptr_reg];
    assign q_first   = q_first_reg[rd_ptr_reg];
    assign q_channel = q_chan_reg[rd_ptr_reg];
    assign q_pitch   = q_pitch_reg[rd_ptr_reg];
    assign q_tick    = q_tick_reg[rd_ptr_reg];
    assign q_id      = q_id_reg[rd_ptr_reg];

endmodule

// ----- hw/rtl/nois_back.sv -----
// Back end: open-note stack in memory, top-down search, compaction and result register.
module nois_back
    import nois_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  op_t                              q_op,
    input  logic                             q_first,
    input  logic [CHAN_W-1:0]                q_channel,
    input  logic [PITCH_W-1:0]               q_pitch,
    input  logic [TICK_W-1:0]                q_tick,
    input  logic [((ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W)-1:0] q_id,
    input  logic [((ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W)-1:0] inval_id,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [NOTE_ID_W-1:0]             result_id,
    output logic                             paired,
    output logic                             stamped,
    output logic                             overflow
);

    localparam int KW    = (ID_WIDTH < NOTE_ID_W) ? ID_WIDTH : NOTE_ID_W;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int EW    = CHAN_W + PITCH_W + TICK_W + KW;
    localparam int TICK_LO  = KW;
    localparam int PITCH_LO = KW + TICK_W;
    localparam int CHAN_LO  = KW + TICK_W + PITCH_W;

    logic [EW-1:0]        mem [STACK_DEPTH];
    logic [EW-1:0]        rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [EW-1:0]        mem_wdata;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [AW-1:0]        ptr_reg;
    logic [AW-1:0]        ptr_next;
    logic [CHAN_W-1:0]    cur_chan_reg;
    logic [CHAN_W-1:0]    cur_chan_next;
    logic [PITCH_W-1:0]   cur_pitch_reg;
    logic [PITCH_W-1:0]   cur_pitch_next;
    logic [TICK_W-1:0]    cur_tick_reg;
    logic [TICK_W-1:0]    cur_tick_next;
    logic [KW-1:0]        cur_id_reg;
    logic [KW-1:0]        cur_id_next;

    logic                 out_valid_reg;
    logic [KW-1:0]        out_id_reg;
    logic                 out_paired_reg;
    logic                 out_stamped_reg;
    logic                 out_ovf_reg;
    logic                 out_load;
    logic [KW-1:0]        out_id_next;
    logic                 out_paired_next;
    logic                 out_stamped_next;
    logic                 out_ovf_next;
    logic                 out_free;

    logic [CW-1:0]        eff_count;
    logic [CHAN_W-1:0]    cand_chan;
    logic [PITCH_W-1:0]   cand_pitch;
    logic [TICK_W-1:0]    cand_tick;
    logic [KW-1:0]        cand_id;
    logic                 hit;
    logic                 stamp;

    assign cand_chan  = rd_data_reg[CHAN_LO +: CHAN_W];
    assign cand_pitch = rd_data_reg[PITCH_LO +: PITCH_W];
    assign cand_tick  = rd_data_reg[TICK_LO +: TICK_W];
    assign cand_id    = rd_data_reg[KW-1:0];

    assign hit   = (cand_chan == cur_chan_reg) && (cand_pitch == cur_pitch_reg)
                   && (cand_tick < cur_tick_reg);
    assign stamp = (cur_id_reg == inval_id) && (cand_id != inval_id);

    assign out_free  = !out_valid_reg || !out_stall;
    assign eff_count = q_first ? '0 : count_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        cur_chan_next    = cur_chan_reg;
        cur_pitch_next   = cur_pitch_reg;
        cur_tick_next    = cur_tick_reg;
        cur_id_next      = cur_id_reg;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg;
        mem_wdata        = rd_data_reg;
        rd_addr          = ptr_reg;
        out_load         = 1'b0;
        out_id_next      = cur_id_reg;
        out_paired_next  = 1'b0;
        out_stamped_next = 1'b0;
        out_ovf_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = AW'(eff_count - CW'(1));
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    count_next     = eff_count;
                    cur_chan_next  = q_channel;
                    cur_pitch_next = q_pitch;
                    cur_tick_next  = q_tick;
                    cur_id_next    = q_id;
                    out_id_next    = q_id;
                    case (q_op)
                        OP_ON:
                        begin
                            out_load = 1'b1;
                            if (eff_count == CW'(STACK_DEPTH))
                            begin
                                out_ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(eff_count);
                                mem_wdata  = {q_channel, q_pitch, q_tick, q_id};
                                count_next = eff_count + CW'(1);
                            end
                        end
                        OP_OFF:
                        begin
                            if (eff_count == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = AW'(eff_count - CW'(1));
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    out_load         = 1'b1;
                    out_paired_next  = 1'b1;
                    out_stamped_next = stamp;
                    out_id_next      = stamp ? cand_id : cur_id_reg;
                    if ((CW'(ptr_reg) + CW'(1)) == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_addr    = AW'(CW'(ptr_reg) + CW'(1));
                        state_next = ST_SHIFT;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                    rd_addr  = ptr_reg - AW'(1);
                end
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rd_data_reg;
                if ((CW'(ptr_reg) + CW'(2)) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                    rd_addr  = AW'(CW'(ptr_reg) + CW'(2));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_chan_reg  <= cur_chan_next;
        cur_pitch_reg <= cur_pitch_next;
        cur_tick_reg  <= cur_tick_next;
        cur_id_reg    <= cur_id_next;
        if (out_load)
        begin
            out_id_reg      <= out_id_next;
            out_paired_reg  <= out_paired_next;
            out_stamped_reg <= out_stamped_next;
            out_ovf_reg     <= out_ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_id = NOTE_ID_W'(out_id_reg);
    assign paired    = out_paired_reg;
    assign stamped   = out_stamped_reg;
    assign overflow  = out_ovf_reg;

endmodule

// ----- test/note_off_id_stamper_tb.sv -----
// Self-checking testbench for the note-off id stamper with a built-in open-note predictor.
module note_off_id_stamper_tb
    import nois_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic                 first;
        logic [KIND_W-1:0]    kind;
        logic [CHAN_W-1:0]    channel;
        logic [PITCH_W-1:0]   pitch;
        logic [VEL_W-1:0]     velocity;
        logic [TICK_W-1:0]    tick;
        logic [NOTE_ID_W-1:0] note_id;
    } note_event_t;

    typedef struct packed {
        logic [NOTE_ID_W-1:0] id;
        logic                 paired;
        logic                 stamped;
        logic                 overflow;
    } stamp_result_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    channel;
        logic [PITCH_W-1:0]   pitch;
        logic [TICK_W-1:0]    tick;
        logic [NOTE_ID_W-1:0] id;
    } held_note_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [NOTE_ID_W-1:0] cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 first;
    logic [KIND_W-1:0]    event_kind;
    logic [CHAN_W-1:0]    channel;
    logic [PITCH_W-1:0]   pitch;
    logic [VEL_W-1:0]     velocity;
    logic [TICK_W-1:0]    tick;
    logic [NOTE_ID_W-1:0] note_id;
    logic                 out_valid;
    logic                 out_stall;
    logic [NOTE_ID_W-1:0] result_id;
    logic                 paired;
    logic                 stamped;
    logic                 overflow;

    held_note_t           held_notes [STACK_DEPTH_DEF];
    int                   held_cnt = 0;
    logic [NOTE_ID_W-1:0] cur_invalid = '0;
    stamp_result_t        pending_results [$];
    int                   mismatch_count = 0;
    int                   result_count = 0;
    int                   cycle_cnt = 0;
    int                   burst_left = 4;
    bit                   gaps_on = 1'b1;
    int                   stall_mode = 1;
    int                   rx_phase = 0;
    int                   hold_len = 0;
    int                   hold_cnt = 0;
    bit                   hold_tog = 1'b0;
    bit                   hold_seen = 1'b0;

    note_off_id_stamper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first       (first),
        .event_kind  (event_kind),
        .channel     (channel),
        .pitch       (pitch),
        .velocity    (velocity),
        .tick        (tick),
        .note_id     (note_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_id   (result_id),
        .paired      (paired),
        .stamped     (stamped),
        .overflow    (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[note_off_id_stamper] ERROR");
            $finish;
        end
    end

    function automatic stamp_result_t stamp_predict(input note_event_t ev);
        stamp_result_t res;
        held_note_t    cand;
        op_t           op;
        res.id       = ev.note_id;
        res.paired   = 1'b0;
        res.stamped  = 1'b0;
        res.overflow = 1'b0;
        if (ev.first)
            held_cnt = 0;
        if (ev.kind == KIND_ON && ev.velocity != '0)
            op = OP_ON;
        else if (ev.kind == KIND_OFF || ev.kind == KIND_ON)
            op = OP_OFF;
        else
            op = OP_OTHER;
        case (op)
            OP_ON:
            begin
                if (held_cnt >= STACK_DEPTH_DEF)
                    res.overflow = 1'b1;
                else
                begin
                    held_notes[held_cnt] = '{ev.channel, ev.pitch, ev.tick, ev.note_id};
                    held_cnt++;
                end
            end
            OP_OFF:
            begin
                for (int s = held_cnt - 1; s >= 0; s--)
                begin
                    cand = held_notes[s];
                    if (cand.channel == ev.channel && cand.pitch == ev.pitch
                        && cand.tick < ev.tick)
                    begin
                        for (int j = s; j < held_cnt - 1; j++)
                            held_notes[j] = held_notes[j + 1];
                        held_cnt--;
                        res.paired = 1'b1;
                        if (ev.note_id == cur_invalid && cand.id != cur_invalid)
                        begin
                            res.id      = cand.id;
                            res.stamped = 1'b1;
                        end
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic note_event_t mk_event(input logic f, input logic [KIND_W-1:0] k,
                                             input logic [CHAN_W-1:0] ch,
                                             input logic [PITCH_W-1:0] p,
                                             input logic [VEL_W-1:0] v,
                                             input logic [TICK_W-1:0] t,
                                             input logic [NOTE_ID_W-1:0] id);
        note_event_t ev;
        ev = '{f, k, ch, p, v, t, id};
        return ev;
    endfunction

    // The receiver stalls on its own pattern; a long hold-off overrides it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 1'b0;
            rx_phase  <= 0;
        end
        else
        begin
            rx_phase <= (rx_phase + 1) % 7;
            if (hold_tog != hold_seen)
            begin
                hold_seen <= hold_tog;
                hold_cnt  <= hold_len;
                out_stall <= 1'b1;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= (rx_phase < 3);
                    3: out_stall <= ($urandom_range(0, 99) < 70);
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        stamp_result_t got;
        stamp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{result_id, paired, stamped, overflow};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d: id=%h paired=%b stamped=%b overflow=%b",
                             result_count, got.id, got.paired, got.stamped, got.overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.id !== want.id || got.paired !== want.paired
                    || got.stamped !== want.stamped || got.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d mismatch: expected id=%h paired=%b stamped=%b overflow=%b",
                                 result_count, want.id, want.paired, want.stamped,
                                 want.overflow);
                        $display("result %0d actual: id=%h paired=%b stamped=%b overflow=%b",
                                 result_count, got.id, got.paired, got.stamped, got.overflow);
                    end
                end
            end
            result_count++;
        end
    end

    task automatic send_event(input note_event_t ev);
        in_valid   <= 1'b1;
        first      <= ev.first;
        event_kind <= ev.kind;
        channel    <= ev.channel;
        pitch      <= ev.pitch;
        velocity   <= ev.velocity;
        tick       <= ev.tick;
        note_id    <= ev.note_id;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.insert(pending_results.size(), stamp_predict(ev));
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_invalid_id(input logic [NOTE_ID_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_invalid = value;
    endtask

    task automatic test_directed();
        write_invalid_id(16'h0000);
        send_event(mk_event(1'b1, KIND_OTHER, 4'hF, 7'h7F, 7'h7F, 32'hFFFF_FFFF, 16'hFFFF));
        send_event(mk_event(1'b0, KIND_RSVD, 4'hF, 7'h7F, 7'h00, 32'h0, 16'hFFFF));
        send_event(mk_event(1'b0, KIND_OFF, 4'h0, 7'h00, 7'h00, 32'd100, 16'h0000));
        send_event(mk_event(1'b0, KIND_ON, 4'h0, 7'h00, 7'h01, 32'd0, 16'h0000));
        send_event(mk_event(1'b0, KIND_ON, 4'h0, 7'h00, 7'h7F, 32'd10, 16'h1234));
        send_event(mk_event(1'b0, KIND_ON, 4'hF, 7'h7F, 7'h40, 32'd10, 16'hFFFF));
        send_event(mk_event(1'b0, KIND_OFF, 4'h0, 7'h00, 7'h00, 32'd10, 16'h0000));
        send_event(mk_event(1'b0, KIND_OFF, 4'h0, 7'h00, 7'h7F, 32'd11, 16'h0000));
        send_event(mk_event(1'b0, KIND_OFF, 4'hF, 7'h7F, 7'h00, 32'd5, 16'h0000));
        send_event(mk_event(1'b0, KIND_ON, 4'hF, 7'h7F, 7'h00, 32'hFFFF_FFFF, 16'h0000));
        send_event(mk_event(1'b0, KIND_ON, 4'h3, 7'd60, 7'h20, 32'd20, 16'h0007));
        send_event(mk_event(1'b0, KIND_ON, 4'h3, 7'd60, 7'h21, 32'd21, 16'h0008));
        send_event(mk_event(1'b0, KIND_ON, 4'h3, 7'd60, 7'h22, 32'd22, 16'h0000));
        send_event(mk_event(1'b0, KIND_OFF, 4'h3, 7'd60, 7'h00, 32'd22, 16'h0000));
        send_event(mk_event(1'b0, KIND_OFF, 4'h3, 7'd60, 7'h00, 32'd30, 16'h0055));
        send_event(mk_event(1'b0, KIND_ON, 4'h3, 7'd60, 7'h22, 32'd31, 16'h0009));
        send_event(mk_event(1'b0, KIND_ON, 4'h5, 7'd10, 7'h01, 32'd1, 16'h0009));
        send_event(mk_event(1'b1, KIND_OFF, 4'h5, 7'd10, 7'h00, 32'd2, 16'h0000));
        send_event(mk_event(1'b0, KIND_OFF, 4'h3, 7'd60, 7'h00, 32'd40, 16'h0000));
        wait_idle();
        write_invalid_id(16'hFFFF);
        send_event(mk_event(1'b0, KIND_ON, 4'h1, 7'h01, 7'h05, 32'd5, 16'hABCD));
        send_event(mk_event(1'b0, KIND_OFF, 4'h1, 7'h01, 7'h00, 32'd6, 16'hFFFF));
        send_event(mk_event(1'b0, KIND_ON, 4'h1, 7'h01, 7'h05, 32'd7, 16'hFFFF));
        send_event(mk_event(1'b0, KIND_OFF, 4'h1, 7'h01, 7'h00, 32'd8, 16'hFFFF));
        wait_idle();
    endtask

    // Fills the stack past its depth while the receiver holds off, then drains it.
    task automatic test_overflow();
        int order [STACK_DEPTH_DEF];
        int pick;
        int swap;
        for (int i = 0; i < STACK_DEPTH_DEF; i++)
            order[i] = i;
        for (int i = STACK_DEPTH_DEF - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
        end
        gaps_on  = 1'b0;
        hold_len <= HOLD_CYCLES;
        hold_tog <= ~hold_tog;
        for (int i = 0; i < STACK_DEPTH_DEF + 2; i++)
            send_event(mk_event(i == 0, KIND_ON, CHAN_W'(i), PITCH_W'(i + 40),
                                VEL_W'($urandom_range(1, 127)), 32'd1000 + 32'(i),
                                NOTE_ID_W'($urandom)));
        gaps_on = 1'b1;
        for (int i = 0; i < STACK_DEPTH_DEF; i++)
            send_event(mk_event(1'b0, KIND_OFF, CHAN_W'(order[i]), PITCH_W'(order[i] + 40),
                                VEL_W'($urandom), 32'd5000,
                                $urandom_range(0, 1) ? cur_invalid : NOTE_ID_W'($urandom)));
        wait_idle();
    endtask

    task automatic test_random(input int n_items, input logic [NOTE_ID_W-1:0] inv,
                               input int rx_mode, input bit with_gaps);
        note_event_t          ev;
        logic [CHAN_W-1:0]    pool_ch [6];
        logic [PITCH_W-1:0]   pool_p [6];
        logic [TICK_W-1:0]    now;
        int                   r;
        int                   k;
        wait_idle();
        write_invalid_id(inv);
        stall_mode <= rx_mode;
        gaps_on = with_gaps;
        for (int i = 0; i < 6; i++)
        begin
            pool_ch[i] = CHAN_W'($urandom);
            pool_p[i]  = PITCH_W'($urandom);
        end
        now = $urandom;
        for (int i = 0; i < n_items; i++)
        begin
            r   = $urandom_range(0, 99);
            k   = $urandom_range(0, 5);
            now = now + $urandom_range(0, 3);
            ev.first    = ($urandom_range(0, 49) == 0);
            ev.channel  = pool_ch[k];
            ev.pitch    = pool_p[k];
            ev.tick     = now;
            ev.velocity = VEL_W'($urandom_range(1, 127));
            ev.note_id  = $urandom_range(0, 1) ? inv : NOTE_ID_W'($urandom);
            if (r < 45)
                ev.kind = KIND_ON;
            else if (r < 75)
            begin
                ev.kind     = KIND_OFF;
                ev.velocity = VEL_W'($urandom);
            end
            else if (r < 85)
            begin
                ev.kind     = KIND_ON;
                ev.velocity = '0;
            end
            else if (r < 92)
            begin
                ev.kind     = KIND_OFF;
                ev.channel  = CHAN_W'($urandom);
                ev.pitch    = PITCH_W'($urandom);
                ev.velocity = VEL_W'($urandom);
                ev.tick     = $urandom;
            end
            else
            begin
                ev.kind     = (r < 96) ? KIND_OTHER : KIND_RSVD;
                ev.channel  = CHAN_W'($urandom);
                ev.pitch    = PITCH_W'($urandom);
                ev.velocity = VEL_W'($urandom);
                ev.tick     = $urandom;
            end
            send_event(ev);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        first       = 1'b0;
        event_kind  = KIND_OTHER;
        channel     = '0;
        pitch       = '0;
        velocity    = '0;
        tick        = '0;
        note_id     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random(110, 16'h0000, 1, 1'b1);
        test_random(110, 16'hFFFF, 2, 1'b1);
        test_random(110, NOTE_ID_W'($urandom), 3, 1'b1);
        test_random(110, 16'h8000, 0, 1'b0);
        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[note_off_id_stamper] OK");
        else
            $display("[note_off_id_stamper] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/nois_pkg.sv
hw/rtl/nois_front.sv
hw/rtl/nois_back.sv
hw/rtl/note_off_id_stamper.sv
test/note_off_id_stamper_tb.sv
